@@ hw/rtl/canonical_huffman_decoder_assert.svh @@
// Assertion macros for the canonical Huffman decoder checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CANONICAL_HUFFMAN_DECODER_ASSERT_SVH
`define CANONICAL_HUFFMAN_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHD_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHD_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/chd_pkg.sv @@
// Shared types and codes for the canonical Huffman decoder.
// No dependencies; chd_len_store, the top level and the checker refer to it by scoped names.
`default_nettype none

package chd_pkg;

	parameter int SYMBOL_COUNT_DEF    = 256;
	parameter int MAX_CODE_LENGTH_DEF = 16;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_BUILD  = 3'd2;
	localparam logic [2:0] OP_DECODE = 3'd3;
	localparam logic [2:0] OP_EOS    = 3'd4;

	localparam logic [1:0] KIND_SYMBOL = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_EOS    = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_OVER  = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] symbol;
		logic [4:0] code_length;
		logic       stream_bit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] decoded_symbol;
		logic [1:0] build_status;
		logic [4:0] dropped_bits;
	} rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/chd_stream_if.sv @@
// Valid/ready channel carrying one payload beat per handshake.
// Payload type comes from chd_pkg at the point of instantiation.
`default_nettype none

interface chd_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/chd_len_store.sv @@
// Code length store: one length per symbol, read one address per cycle.
// Per-entry valid bits make unwritten or cleared entries read as zero.
`default_nettype none

module chd_len_store #(
	parameter int SYMBOL_COUNT = chd_pkg::SYMBOL_COUNT_DEF,
	parameter int LEN_W        = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            clr,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(SYMBOL_COUNT)-1:0] wr_addr,
	input  wire logic [LEN_W-1:0]                wr_len,
	input  wire logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr,
	output logic      [LEN_W-1:0]                rd_len
);

	logic [LEN_W-1:0]        mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic [LEN_W-1:0]        rd_data_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_len;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_len = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/canonical_huffman_decoder.sv @@
// Canonical Huffman decoder top level: command sequencer, code tables, output register.
// Depends on chd_pkg, chd_stream_if and chd_len_store.
//
//   port  dir  payload         carries
//   cmd   in   chd_pkg::cmd_t  clear, load, build, decode bit, end of stream
//   rsp   out  chd_pkg::rsp_t  decoded symbol, build status, end of stream report
//
// Clear, load, ignored ops and unmatched decode bits use only the execute state, end of
// stream adds the emit state, and a decode bit that completes a code does table lookup,
// then symbol store read, then emit. An ok build makes two scans of the length store at
// one read per cycle, and handles one code length per cycle in between.
// Reset empties the code tables and length store at once; there is no clearing pass.
// A result waiting in the output register stalls the block only when the next
// result is ready to leave.
`default_nettype none

module canonical_huffman_decoder #(
	parameter int SYMBOL_COUNT    = chd_pkg::SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_LENGTH = chd_pkg::MAX_CODE_LENGTH_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	chd_stream_if.sink   cmd,
	chd_stream_if.source rsp
);

	localparam int SW = $clog2(SYMBOL_COUNT);
	localparam int NW = $clog2(SYMBOL_COUNT + 1);
	localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
	localparam int CW = MAX_CODE_LENGTH;
	localparam int FW = CW + 1;
	localparam int DW = ((FW > NW) ? FW : NW) + 1;
	localparam int RW = NW + 2;
	localparam int LD = MAX_CODE_LENGTH + 1;

	localparam logic [SW:0]          SCAN_END = (SW + 1)'(SYMBOL_COUNT);
	localparam logic [LW-1:0]        LEN_MAX  = LW'(MAX_CODE_LENGTH);
	localparam logic signed [RW-1:0] ROOM_CAP = RW'(SYMBOL_COUNT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_COUNT = 3'd2;
	localparam logic [2:0] ST_KRAFT = 3'd3;
	localparam logic [2:0] ST_PLACE = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]           state_q;
	chd_pkg::cmd_t        cmd_q;
	logic                 table_ready_q;
	logic [CW-1:0]        partial_q;
	logic [LW-1:0]        plen_q;

	logic [NW-1:0]        cnt_q    [LD];
	logic [FW-1:0]        first_q  [LD];
	logic [NW-1:0]        offset_q [LD];
	logic [NW-1:0]        fill_q   [LD];

	logic [SW:0]          scan_q;
	logic                 pend_s1;
	logic [SW-1:0]        scan_sym_s1;
	logic                 any_q;

	logic [LW-1:0]        lvl_q;
	logic signed [RW-1:0] room_q;
	logic [FW-1:0]        code_q;
	logic [NW-1:0]        prev_cnt_q;
	logic [NW-1:0]        off_acc_q;

	logic [SW-1:0]        sorted_mem [SYMBOL_COUNT];
	logic [SW-1:0]        sorted_rd_q;
	logic [SW-1:0]        idx_q;

	chd_pkg::rsp_t        res_q;
	chd_pkg::rsp_t        out_q;
	logic                 out_valid_q;

	logic [LW-1:0]        rd_len;
	logic                 load_ok;
	logic                 scan_done;
	logic                 emit_fire;

	logic [CW-1:0]        code_n;
	logic [LW-1:0]        len_n;
	logic [NW-1:0]        d_cnt;
	logic [FW-1:0]        d_first;
	logic [DW-1:0]        d_diff;
	logic                 dec_hit;
	logic [SW-1:0]        dec_idx;

	logic [NW-1:0]        cur_cnt;
	logic signed [RW-1:0] room_next;
	logic [DW-1:0]        code_sum;
	logic [FW-1:0]        code_next;
	logic [NW-1:0]        off_next;

	logic                 place_we;
	logic [SW-1:0]        place_addr;

	chd_len_store #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.LEN_W       (LW)
	) u_len_store (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (state_q == ST_EXEC && cmd_q.operation == chd_pkg::OP_CLEAR),
		.wr_en  (state_q == ST_EXEC && cmd_q.operation == chd_pkg::OP_LOAD && load_ok),
		.wr_addr(SW'(cmd_q.symbol)),
		.wr_len (LW'(cmd_q.code_length)),
		.rd_addr(SW'(scan_q)),
		.rd_len (rd_len)
	);

	assign load_ok = ({1'b0, cmd_q.symbol} < 9'(SYMBOL_COUNT))
		&& (6'(cmd_q.code_length) <= 6'(MAX_CODE_LENGTH));
	assign scan_done = (scan_q == SCAN_END) && !pend_s1;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	// Decode: compare the grown code against the first code of its length.
	always_comb begin
		code_n  = CW'({partial_q, cmd_q.stream_bit});
		len_n   = plen_q + LW'(1);
		d_cnt   = cnt_q[len_n];
		d_first = first_q[len_n];
		d_diff  = DW'(code_n) - DW'(d_first);
		dec_hit = (d_cnt != '0) && (DW'(code_n) >= DW'(d_first)) && (d_diff < DW'(d_cnt));
		dec_idx = SW'(NW'(d_diff) + offset_q[len_n]);
	end

	// One code length per step: Kraft room, first code and offset.
	always_comb begin
		cur_cnt   = cnt_q[lvl_q];
		room_next = $signed({room_q[RW-2:0], 1'b0}) - $signed({2'b00, cur_cnt});
		code_sum  = DW'(code_q) + DW'(prev_cnt_q);
		code_next = FW'(code_sum << 1);
		off_next  = off_acc_q + prev_cnt_q;
	end

	assign place_we   = (state_q == ST_PLACE) && pend_s1 && (rd_len != '0);
	assign place_addr = SW'(fill_q[rd_len]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_ready_q <= 1'b0;
			partial_q     <= '0;
			plen_q        <= '0;
			for (int l = 0; l < LD; l++) begin
				cnt_q[l]    <= '0;
				first_q[l]  <= '0;
				offset_q[l] <= '0;
				fill_q[l]   <= '0;
			end
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			any_q       <= 1'b0;
			lvl_q       <= '0;
			room_q      <= '0;
			code_q      <= '0;
			prev_cnt_q  <= '0;
			off_acc_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.operation)
						chd_pkg::OP_CLEAR: begin
							state_q       <= ST_IDLE;
							table_ready_q <= 1'b0;
							partial_q     <= '0;
							plen_q        <= '0;
							for (int l = 0; l < LD; l++) begin
								cnt_q[l]    <= '0;
								first_q[l]  <= '0;
								offset_q[l] <= '0;
							end
						end
						chd_pkg::OP_LOAD: begin
							state_q <= ST_IDLE;
							if (load_ok) begin
								table_ready_q <= 1'b0;
								partial_q     <= '0;
								plen_q        <= '0;
							end
						end
						chd_pkg::OP_BUILD: begin
							table_ready_q <= 1'b0;
							partial_q     <= '0;
							plen_q        <= '0;
							for (int l = 0; l < LD; l++) begin
								cnt_q[l] <= '0;
							end
							any_q   <= 1'b0;
							scan_q  <= '0;
							pend_s1 <= 1'b0;
							state_q <= ST_COUNT;
						end
						chd_pkg::OP_DECODE: begin
							if (!table_ready_q) begin
								state_q <= ST_IDLE;
							end else if (dec_hit) begin
								partial_q <= '0;
								plen_q    <= '0;
								state_q   <= ST_READ;
							end else if (len_n == LEN_MAX) begin
								// drop an unmatched code at full length
								partial_q <= '0;
								plen_q    <= '0;
								state_q   <= ST_IDLE;
							end else begin
								partial_q <= code_n;
								plen_q    <= len_n;
								state_q   <= ST_IDLE;
							end
						end
						chd_pkg::OP_EOS: begin
							partial_q <= '0;
							plen_q    <= '0;
							state_q   <= ST_EMIT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_COUNT: begin
					if (scan_q != SCAN_END) begin
						scan_q  <= scan_q + (SW + 1)'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && rd_len != '0) begin
						cnt_q[rd_len] <= cnt_q[rd_len] + NW'(1);
						any_q         <= 1'b1;
					end
					if (scan_done) begin
						if (any_q) begin
							lvl_q      <= LW'(1);
							room_q     <= RW'(1);
							code_q     <= '0;
							prev_cnt_q <= '0;
							off_acc_q  <= '0;
							state_q    <= ST_KRAFT;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_KRAFT: begin
					first_q[lvl_q]  <= code_next;
					offset_q[lvl_q] <= off_next;
					fill_q[lvl_q]   <= off_next;
					code_q          <= code_next;
					off_acc_q       <= off_next;
					prev_cnt_q      <= cur_cnt;
					// room never shrinks once it covers every symbol: saturate there
					room_q          <= (room_next > ROOM_CAP) ? ROOM_CAP : room_next;
					lvl_q           <= lvl_q + LW'(1);
					if (room_next[RW-1]) begin
						state_q <= ST_EMIT;
					end else if (lvl_q == LEN_MAX) begin
						scan_q  <= '0;
						pend_s1 <= 1'b0;
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (scan_q != SCAN_END) begin
						scan_q  <= scan_q + (SW + 1)'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (place_we) begin
						fill_q[rd_len] <= fill_q[rd_len] + NW'(1);
					end
					if (scan_done) begin
						table_ready_q <= 1'b1;
						state_q       <= ST_EMIT;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.payload;
		end
		scan_sym_s1 <= SW'(scan_q);
		case (state_q)
			ST_EXEC: begin
				idx_q <= dec_idx;
				if (cmd_q.operation == chd_pkg::OP_EOS) begin
					res_q <= '{kind: chd_pkg::KIND_EOS, decoded_symbol: '0,
						build_status: chd_pkg::STATUS_OK, dropped_bits: 5'(plen_q)};
				end else begin
					res_q <= '{kind: chd_pkg::KIND_SYMBOL, decoded_symbol: '0,
						build_status: chd_pkg::STATUS_OK, dropped_bits: '0};
				end
			end
			ST_COUNT: begin
				res_q <= '{kind: chd_pkg::KIND_STATUS, decoded_symbol: '0,
					build_status: chd_pkg::STATUS_EMPTY, dropped_bits: '0};
			end
			ST_KRAFT: begin
				res_q <= '{kind: chd_pkg::KIND_STATUS, decoded_symbol: '0,
					build_status: chd_pkg::STATUS_OVER, dropped_bits: '0};
			end
			ST_PLACE: begin
				res_q <= '{kind: chd_pkg::KIND_STATUS, decoded_symbol: '0,
					build_status: chd_pkg::STATUS_OK, dropped_bits: '0};
			end
			default: begin
			end
		endcase
		if (emit_fire) begin
			if (res_q.kind == chd_pkg::KIND_SYMBOL) begin
				out_q <= '{kind: res_q.kind, decoded_symbol: 8'(sorted_rd_q),
					build_status: res_q.build_status, dropped_bits: res_q.dropped_bits};
			end else begin
				out_q <= res_q;
			end
		end
	end

	// Symbol store: written during the placement scan, read at the decoded index.
	always_ff @(posedge clk) begin
		if (place_we) begin
			sorted_mem[place_addr] <= scan_sym_s1;
		end
		sorted_rd_q <= sorted_mem[idx_q];
	end

	assign cmd.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/chd_checker.sv @@
// Port-level checks for the canonical Huffman decoder, bound to the top level.
// Depends on chd_pkg and canonical_huffman_decoder_assert.svh.
`default_nettype none
`include "canonical_huffman_decoder_assert.svh"

module chd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire chd_pkg::rsp_t rsp_payload
);

	// every accepted command drops cmd ready: the sequencer leaves idle to execute it
	`CHD_NEXT(a_busy_after_beat, cmd_valid && cmd_ready, !cmd_ready, "ready right after a beat")

	`CHD_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

	`CHD_IMPLIES(a_symbol_fields, rsp_valid && rsp_payload.kind == chd_pkg::KIND_SYMBOL, rsp_payload.build_status == chd_pkg::STATUS_OK && rsp_payload.dropped_bits == 5'd0, "symbol beat carries stray fields")

	`CHD_IMPLIES(a_status_fields, rsp_valid && rsp_payload.kind == chd_pkg::KIND_STATUS, rsp_payload.decoded_symbol == 8'd0 && rsp_payload.dropped_bits == 5'd0, "status beat carries stray fields")

endmodule

bind canonical_huffman_decoder chd_checker u_chd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_payload(rsp.payload)
);

`default_nettype wire
